>>> hdl/hps_pkg.sv
package hps_pkg;

   // field widths
   localparam int unsigned HeadingW = 12;
   localparam int unsigned ErrW     = 12;
   localparam int unsigned WidthW   = 16;
   localparam int unsigned GainW    = 24;
   localparam int unsigned TotalW   = 32;
   localparam int unsigned ModeW    = 2;
   localparam int unsigned CsrIdxW  = 3;

   // datapath widths of the PI law
   localparam int unsigned ProdPW = GainW + ErrW;     // 36
   localparam int unsigned ProdIW = GainW + TotalW;   // 56
   localparam int unsigned AccW   = ProdIW + 1;       // 57
   localparam int unsigned QuotW  = AccW - 16;        // 41

   // heading wrap and k-turn limits, tenths of a degree
   localparam logic [HeadingW-1:0]      WRAP_HALF   = 12'd1800;
   localparam logic [HeadingW:0]        WRAP_FULL   = 13'd3600;
   localparam logic signed [ErrW-1:0]   KTURN_LIMIT = 12'sd1350;
   localparam logic [WidthW-1:0]        PWM_TOP     = 16'hFFFF;

   // steering modes
   localparam logic [ModeW-1:0] MODE_NORMAL     = 2'd0;
   localparam logic [ModeW-1:0] MODE_KTURN_HIGH = 2'd1;
   localparam logic [ModeW-1:0] MODE_KTURN_LOW  = 2'd2;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_MOTOR_NEUTRAL = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_MOTOR_LOW     = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_MOTOR_HIGH    = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_SERVO_NEUTRAL = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_SERVO_LOW     = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_SERVO_HIGH    = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_PROP_GAIN     = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_INTEG_GAIN    = 3'd7;

   // register reset values
   localparam logic [WidthW-1:0]       RST_MOTOR_NEUTRAL = 16'd2765;
   localparam logic [WidthW-1:0]       RST_MOTOR_LOW     = 16'd2028;
   localparam logic [WidthW-1:0]       RST_MOTOR_HIGH    = 16'd3502;
   localparam logic [WidthW-1:0]       RST_SERVO_NEUTRAL = 16'd2765;
   localparam logic [WidthW-1:0]       RST_SERVO_LOW     = 16'd1659;
   localparam logic [WidthW-1:0]       RST_SERVO_HIGH    = 16'd3871;
   localparam logic signed [GainW-1:0] RST_PROP_GAIN     = -24'sd98271;
   localparam logic signed [GainW-1:0] RST_INTEG_GAIN    = -24'sd853;

   typedef struct packed {
      logic [WidthW-1:0]       motor_neutral;
      logic [WidthW-1:0]       motor_low;
      logic [WidthW-1:0]       motor_high;
      logic [WidthW-1:0]       servo_neutral;
      logic [WidthW-1:0]       servo_low;
      logic [WidthW-1:0]       servo_high;
      logic signed [GainW-1:0] prop_gain;
      logic signed [GainW-1:0] integ_gain;
   } cfg_type;

   typedef struct packed {
      logic signed [ErrW-1:0]   err;
      logic [ModeW-1:0]         mode;
      logic signed [TotalW-1:0] total;
      logic                     motor_hold;
      logic                     servo_hold;
   } err_stage_type;

   typedef struct packed {
      logic signed [ProdPW-1:0] prod_p;
      logic signed [ProdIW-1:0] prod_i;
      logic signed [ErrW-1:0]   err;
      logic [ModeW-1:0]         mode;
      logic                     motor_hold;
      logic                     servo_hold;
   } prod_stage_type;

   typedef struct packed {
      logic signed [QuotW-1:0] quot;
      logic signed [ErrW-1:0]  err;
      logic [ModeW-1:0]        mode;
      logic                    motor_hold;
      logic                    servo_hold;
   } quot_stage_type;

   typedef struct packed {
      logic signed [ErrW-1:0] err;
      logic [ModeW-1:0]       mode;
      logic [WidthW-1:0]      servo_compare;
      logic [WidthW-1:0]      motor_compare;
      logic [WidthW-1:0]      servo_width;
      logic [WidthW-1:0]      motor_width;
   } rsp_type;

endpackage

>>> hdl/heading_pi_steering_core.sv
// Channel | Direction | Carries
// req_    | in        | compass heading and the two hold switches
// rsp_    | out       | motor/servo widths, compare values, mode, wrapped error
// csr_    | in        | write-only register port, eight registers
//
// One request is taken every cycle while req_tready is high; a response passes the
// input, error, product, quotient and output registers. The rate is set by the error
// total loop: one saturating add per cycle in the error stage.
// Reset clears all stage valid flags and the error total, and loads the
// register defaults. While rsp_tready is low the stages fill up one by one;
// req_tready drops only once every stage holds a request.
module heading_pi_steering_core
   import hps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // [11:0] compass_heading, [12] motor_hold, [13] servo_hold, [15:14] zero
   input  logic [15:0]        req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [15:0] motor_width, [31:16] servo_width, [47:32] motor_compare,
   // [63:48] servo_compare, [65:64] steer_mode, [77:66] wrapped_error, [79:78] zero
   output logic [79:0]        rsp_tdata,
   input  logic               csr_wen,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [GainW-1:0]   csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   logic           err_valid, err_ready;
   err_stage_type  err_data;
   logic           quot_valid, quot_ready;
   quot_stage_type quot_data;
   rsp_type        rsp_data;

   // write one register per enabled cycle
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_MOTOR_NEUTRAL: cfg_in.motor_neutral = csr_wdata[WidthW-1:0];
            REG_MOTOR_LOW:     cfg_in.motor_low     = csr_wdata[WidthW-1:0];
            REG_MOTOR_HIGH:    cfg_in.motor_high    = csr_wdata[WidthW-1:0];
            REG_SERVO_NEUTRAL: cfg_in.servo_neutral = csr_wdata[WidthW-1:0];
            REG_SERVO_LOW:     cfg_in.servo_low     = csr_wdata[WidthW-1:0];
            REG_SERVO_HIGH:    cfg_in.servo_high    = csr_wdata[WidthW-1:0];
            REG_PROP_GAIN:     cfg_in.prop_gain     = $signed(csr_wdata);
            REG_INTEG_GAIN:    cfg_in.integ_gain    = $signed(csr_wdata);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_neutral <= RST_MOTOR_NEUTRAL;
         cfg_ff.motor_low     <= RST_MOTOR_LOW;
         cfg_ff.motor_high    <= RST_MOTOR_HIGH;
         cfg_ff.servo_neutral <= RST_SERVO_NEUTRAL;
         cfg_ff.servo_low     <= RST_SERVO_LOW;
         cfg_ff.servo_high    <= RST_SERVO_HIGH;
         cfg_ff.prop_gain     <= RST_PROP_GAIN;
         cfg_ff.integ_gain    <= RST_INTEG_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hps_error_stage u_error_stage (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_tvalid),
      .up_ready   (req_tready),
      .heading    (req_tdata[HeadingW-1:0]),
      .motor_hold (req_tdata[HeadingW]),
      .servo_hold (req_tdata[HeadingW+1]),
      .dn_valid   (err_valid),
      .dn_ready   (err_ready),
      .dn_data    (err_data)
   );

   hps_pi_stage u_pi_stage (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (err_valid),
      .up_ready (err_ready),
      .up_data  (err_data),
      .dn_valid (quot_valid),
      .dn_ready (quot_ready),
      .dn_data  (quot_data)
   );

   hps_output_stage u_output_stage (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .up_valid  (quot_valid),
      .up_ready  (quot_ready),
      .up_data   (quot_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   // pack the response, first struct field highest
   assign rsp_tdata = {2'b00, rsp_data};

endmodule

>>> hdl/hps_error_stage.sv
module hps_error_stage
   import hps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  logic [HeadingW-1:0] heading,
   input  logic                motor_hold,
   input  logic                servo_hold,
   output logic                dn_valid,
   input  logic                dn_ready,
   output err_stage_type       dn_data
);

   logic                     s1_valid_ff, s1_valid_in;
   logic [HeadingW-1:0]      s1_heading_ff, s1_heading_in;
   logic                     s1_mhold_ff, s1_mhold_in;
   logic                     s1_shold_ff, s1_shold_in;
   logic                     s2_valid_ff, s2_valid_in;
   err_stage_type            s2_data_ff, s2_data_in;
   logic signed [TotalW-1:0] error_total_ff, error_total_in;

   logic                     s1_ready, s2_ready, s1_move;
   logic signed [HeadingW:0] err_wide;
   logic signed [ErrW-1:0]   err;
   logic [ModeW-1:0]         mode;
   logic signed [ErrW:0]     delta;
   logic signed [TotalW:0]   sum;
   logic signed [TotalW-1:0] total_sat;

   // a stage takes a request when it is empty or its contents move on
   assign s2_ready = !s2_valid_ff || dn_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s1_move  = s1_valid_ff && s2_ready;
   assign up_ready = s1_ready;

   // hold the incoming request
   always_comb begin
      s1_valid_in   = s1_ready ? up_valid : s1_valid_ff;
      s1_heading_in = s1_heading_ff;
      s1_mhold_in   = s1_mhold_ff;
      s1_shold_in   = s1_shold_ff;
      if (s1_ready && up_valid) begin
         s1_heading_in = heading;
         s1_mhold_in   = motor_hold;
         s1_shold_in   = servo_hold;
      end
   end

   // wrap the error toward north once into -1800..1799
   always_comb begin
      if (s1_heading_ff > WRAP_HALF) begin
         err_wide = $signed(WRAP_FULL - {1'b0, s1_heading_ff});
      end else begin
         err_wide = $signed(13'd0 - {1'b0, s1_heading_ff});
      end
      err = err_wide[ErrW-1:0];
   end

   // pick the mode and update the saturating error total
   always_comb begin
      if (err > KTURN_LIMIT) begin
         mode = MODE_KTURN_HIGH;
      end else if (err < -KTURN_LIMIT) begin
         mode = MODE_KTURN_LOW;
      end else begin
         mode = MODE_NORMAL;
      end
      if (mode == MODE_NORMAL) begin
         delta = {err[ErrW-1], err};
      end else begin
         delta = -{err[ErrW-1], err};
      end
      sum = {error_total_ff[TotalW-1], error_total_ff}
          + {{(TotalW - ErrW){delta[ErrW]}}, delta};
      if (sum[TotalW] != sum[TotalW-1]) begin
         total_sat = sum[TotalW] ? {1'b1, {(TotalW-1){1'b0}}} : {1'b0, {(TotalW-1){1'b1}}};
      end else begin
         total_sat = sum[TotalW-1:0];
      end
   end

   // advance into the error register
   always_comb begin
      s2_valid_in    = s2_ready ? s1_valid_ff : s2_valid_ff;
      s2_data_in     = s2_data_ff;
      error_total_in = error_total_ff;
      if (s1_move) begin
         s2_data_in.err        = err;
         s2_data_in.mode       = mode;
         s2_data_in.total      = total_sat;
         s2_data_in.motor_hold = s1_mhold_ff;
         s2_data_in.servo_hold = s1_shold_ff;
         error_total_in        = total_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         error_total_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         error_total_ff <= error_total_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_heading_ff <= s1_heading_in;
      s1_mhold_ff   <= s1_mhold_in;
      s1_shold_ff   <= s1_shold_in;
      s2_data_ff    <= s2_data_in;
   end

   assign dn_valid = s2_valid_ff;
   assign dn_data  = s2_data_ff;

endmodule

>>> hdl/hps_pi_stage.sv
module hps_pi_stage
   import hps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           up_valid,
   output logic           up_ready,
   input  err_stage_type  up_data,
   output logic           dn_valid,
   input  logic           dn_ready,
   output quot_stage_type dn_data
);

   logic           s3_valid_ff, s3_valid_in;
   prod_stage_type s3_data_ff, s3_data_in;
   logic           s4_valid_ff, s4_valid_in;
   quot_stage_type s4_data_ff, s4_data_in;

   logic                    s3_ready, s4_ready;
   logic signed [AccW-1:0]  base, prop_ext, integ_ext, acc;
   logic signed [QuotW-1:0] quot;

   assign s4_ready = !s4_valid_ff || dn_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign up_ready = s3_ready;

   // register both gain products
   always_comb begin
      s3_valid_in = s3_ready ? up_valid : s3_valid_ff;
      s3_data_in  = s3_data_ff;
      if (s3_ready && up_valid) begin
         s3_data_in.prod_p     = cfg.prop_gain * up_data.err;
         s3_data_in.prod_i     = cfg.integ_gain * up_data.total;
         s3_data_in.err        = up_data.err;
         s3_data_in.mode       = up_data.mode;
         s3_data_in.motor_hold = up_data.motor_hold;
         s3_data_in.servo_hold = up_data.servo_hold;
      end
   end

   // sum with the centre and truncate the Q16 result toward zero
   always_comb begin
      base      = {{(AccW - WidthW - 16){1'b0}}, cfg.servo_neutral, 16'd0};
      prop_ext  = {{(AccW - ProdPW){s3_data_ff.prod_p[ProdPW-1]}}, s3_data_ff.prod_p};
      integ_ext = {{(AccW - ProdIW){s3_data_ff.prod_i[ProdIW-1]}}, s3_data_ff.prod_i};
      acc       = base + prop_ext + integ_ext;
      quot      = acc[AccW-1:16];
      if (acc[AccW-1] && (acc[15:0] != 16'd0)) begin
         quot = quot + 41'sd1;
      end
   end

   always_comb begin
      s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;
      s4_data_in  = s4_data_ff;
      if (s4_ready && s3_valid_ff) begin
         s4_data_in.quot       = quot;
         s4_data_in.err        = s3_data_ff.err;
         s4_data_in.mode       = s3_data_ff.mode;
         s4_data_in.motor_hold = s3_data_ff.motor_hold;
         s4_data_in.servo_hold = s3_data_ff.servo_hold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_data_ff <= s3_data_in;
      s4_data_ff <= s4_data_in;
   end

   assign dn_valid = s4_valid_ff;
   assign dn_data  = s4_data_ff;

endmodule

>>> hdl/hps_output_stage.sv
module hps_output_stage
   import hps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           up_valid,
   output logic           up_ready,
   input  quot_stage_type up_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic                    out_ready;
   logic signed [QuotW-1:0] srv, mot;
   logic [WidthW-1:0]       motor_w, servo_w;

   // test the high limit first, then the low one
   function automatic logic [WidthW-1:0] clamp_width(input logic signed [QuotW-1:0] v,
                                                     input logic [WidthW-1:0] lo,
                                                     input logic [WidthW-1:0] hi);
      logic [WidthW-1:0] res;
      if (v > $signed({{(QuotW - WidthW){1'b0}}, hi})) begin
         res = hi;
      end else if (v < $signed({{(QuotW - WidthW){1'b0}}, lo})) begin
         res = lo;
      end else begin
         res = v[WidthW-1:0];
      end
      return res;
   endfunction

   assign out_ready = !out_valid_ff || rsp_ready;
   assign up_ready  = out_ready;

   // select the widths for the mode, clamp, then apply the hold switches
   always_comb begin
      case (up_data.mode)
         MODE_NORMAL: begin
            srv = up_data.quot;
            mot = {{(QuotW - WidthW){1'b0}}, cfg.motor_high};
         end
         MODE_KTURN_HIGH: begin
            srv = {{(QuotW - WidthW){1'b0}}, cfg.servo_high};
            mot = {{(QuotW - WidthW){1'b0}}, cfg.motor_low};
         end
         default: begin
            srv = {{(QuotW - WidthW){1'b0}}, cfg.servo_low};
            mot = {{(QuotW - WidthW){1'b0}}, cfg.motor_low};
         end
      endcase
      motor_w = clamp_width(mot, cfg.motor_low, cfg.motor_high);
      servo_w = clamp_width(srv, cfg.servo_low, cfg.servo_high);
      if (up_data.motor_hold) begin
         motor_w = cfg.motor_neutral;
      end
      if (up_data.servo_hold) begin
         servo_w = cfg.servo_neutral;
      end
   end

   // hold the result until it is taken
   always_comb begin
      out_valid_in = out_ready ? up_valid : out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_ready && up_valid) begin
         out_data_in.motor_width   = motor_w;
         out_data_in.servo_width   = servo_w;
         out_data_in.motor_compare = PWM_TOP - motor_w;
         out_data_in.servo_compare = PWM_TOP - servo_w;
         out_data_in.mode          = up_data.mode;
         out_data_in.err           = up_data.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> hdl/hps_checker.sv
module hps_checker
   import hps_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   logic signed [ErrW-1:0] rsp_err;
   logic [ModeW-1:0]       rsp_mode;

   assign rsp_err  = rsp_tdata[77:66];
   assign rsp_mode = rsp_tdata[65:64];

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // no response straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // compare values follow the widths
   a_compare: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[47:32] == PWM_TOP - rsp_tdata[15:0])
                  && (rsp_tdata[63:48] == PWM_TOP - rsp_tdata[31:16]))
      else $error("compare value does not match width");

   // mode agrees with the wrapped error
   a_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_mode == MODE_NORMAL)
                      == (rsp_err <= KTURN_LIMIT && rsp_err >= -KTURN_LIMIT))
                  && (rsp_mode != MODE_KTURN_HIGH || rsp_err > KTURN_LIMIT)
                  && (rsp_mode != MODE_KTURN_LOW || rsp_err < -KTURN_LIMIT))
      else $error("steer mode does not match wrapped error");

endmodule

bind heading_pi_steering_core hps_checker u_hps_checker (.*);
